// ===== rtl/core/phfc_pkg.sv =====
// Shared constants and types for the pipeline hazard and forwarding control block.
package phfc_pkg;

  localparam int XLEN_DEF     = 64;
  localparam int NUM_REGS_DEF = 32;

  localparam int REG_W = 5;
  localparam int LAT_W = 8;

  localparam logic [63:0] RESET_PC = 64'h0000_0000_8000_0000;
  localparam int          PC_STEP  = 4;

  // Decoded fields of the instruction held in ID
  typedef struct packed {
    logic [REG_W-1:0] rs1;
    logic [REG_W-1:0] rs2;
    logic [REG_W-1:0] rd;
    logic             ld;
  } id_fields_t;

  // Control fields of the instruction held in EX
  typedef struct packed {
    logic [REG_W-1:0] rd;
    logic             ld;
  } ex_fields_t;

endpackage

// ===== rtl/core/phfc_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module phfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/core/pipeline_hazard_forward_control.sv =====
// Top level of the five-stage pipeline hazard, forwarding and fetch control block.
//
// Each accepted input beat is one processor cycle and yields exactly one result beat; a new
// beat is accepted every clock as long as the result register is empty or
// being drained in the same cycle. All decisions for a cycle (write-back, load capture,
// redirect, load-use stall, operand forwarding, fetch address) are made in one pass of logic
// between the stage latches and the result register. The register file sits in a RAM with
// registered reads: operands are read when an instruction enters (or is held in) ID and are
// patched by the write-back that happens at that edge and at the next cycle, so reads always
// see write-before-read values. Entries read as zero until first written after reset. A write
// of start_pc on the configuration channel also loads the fetch address; it is always ready.
module pipeline_hazard_forward_control
  import phfc_pkg::*;
#(
  parameter int XLEN     = XLEN_DEF,
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [XLEN-1:0]  cfg_data,
  // cycle input channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REG_W-1:0] new_rs1,
  input  logic [REG_W-1:0] new_rs2,
  input  logic [REG_W-1:0] new_rd,
  input  logic             new_is_load,
  input  logic [XLEN-1:0]  ex_result,
  input  logic             ex_redirect,
  input  logic [XLEN-1:0]  ex_target,
  input  logic [XLEN-1:0]  mem_load_data,
  input  logic [LAT_W-1:0] mem_latency,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic             issue_valid,
  output logic [XLEN-1:0]  issue_src1,
  output logic [XLEN-1:0]  issue_src2,
  output logic             load_use_stall,
  output logic             frozen,
  output logic [XLEN-1:0]  next_fetch_pc,
  output logic             commit_valid,
  output logic [REG_W-1:0] commit_rd,
  output logic [XLEN-1:0]  commit_value
);

  localparam int AW = $clog2(NUM_REGS);
  localparam logic [REG_W:0] NREGS = (REG_W + 1)'(NUM_REGS);

  // stage latches
  logic             id_v;
  id_fields_t       id_f;
  logic             ex_v;
  ex_fields_t       ex_f;
  logic             mem_v;
  logic [REG_W-1:0] mem_rd;
  logic             mem_ld;
  logic [XLEN-1:0]  mem_val;
  logic             wb_v;
  logic [REG_W-1:0] wb_rd;
  logic [XLEN-1:0]  wb_val;
  logic [XLEN-1:0]  fetch_address;
  logic [LAT_W-1:0] freeze_remaining;

  // register file support
  logic [NUM_REGS-1:0] written;
  logic                rv1;
  logic                rv2;
  logic                lastw_v;
  logic [REG_W-1:0]    lastw_rd;
  logic [XLEN-1:0]     lastw_val;
  logic [XLEN-1:0]     ram_q1;
  logic [XLEN-1:0]     ram_q2;

  logic             step;
  logic             freeze_now;
  logic             run;
  logic             rf_wr_en;
  logic [XLEN-1:0]  mem_res;
  logic             redirect;
  logic             id_eff_v;
  logic             stall;
  logic             issue;
  logic [XLEN-1:0]  rf1;
  logic [XLEN-1:0]  rf2;
  logic [XLEN-1:0]  s1;
  logic [XLEN-1:0]  s2;
  logic [REG_W-1:0] rd_addr1;
  logic [REG_W-1:0] rd_addr2;
  logic [XLEN-1:0]  fetch_address_next;
  logic [LAT_W-1:0] freeze_next;

  assign cfg_ready  = 1'b1;
  assign in_ready   = !out_valid || out_ready;
  assign step       = in_valid && in_ready;
  assign freeze_now = (freeze_remaining != '0);
  assign run        = step && !freeze_now;

  // write-back into the register file; register zero and out-of-range numbers are dropped
  assign rf_wr_en = run && wb_v && (wb_rd != '0) && ({1'b0, wb_rd} < NREGS);

  function automatic logic [XLEN-1:0] rf_value(
    input logic [REG_W-1:0] r,
    input logic             wr_en,
    input logic [REG_W-1:0] wr_rd,
    input logic [XLEN-1:0]  wr_val,
    input logic             lw_v,
    input logic [REG_W-1:0] lw_rd,
    input logic [XLEN-1:0]  lw_val,
    input logic             rv,
    input logic [XLEN-1:0]  q
  );
    logic [XLEN-1:0] v;
    if (wr_en && wr_rd == r) begin
      v = wr_val;
    end else if (lw_v && lw_rd == r) begin
      v = lw_val;
    end else if (rv) begin
      v = q;
    end else begin
      v = '0;
    end
    if (r == '0 || {1'b0, r} >= NREGS) begin
      v = '0;
    end
    return v;
  endfunction

  always_comb begin
    mem_res     = mem_val;
    freeze_next = freeze_remaining;
    if (freeze_now) begin
      freeze_next = freeze_remaining - LAT_W'(1);
    end else if (mem_v && mem_ld) begin
      mem_res = mem_load_data;
      if (mem_latency > LAT_W'(1)) begin
        freeze_next = mem_latency - LAT_W'(1);
      end
    end

    redirect = ex_v && ex_redirect;
    id_eff_v = id_v && !redirect;
    stall    = id_eff_v && ex_v && ex_f.ld && (ex_f.rd != '0) &&
               (ex_f.rd == id_f.rs1 || ex_f.rd == id_f.rs2);
    issue    = id_eff_v && !stall;

    rf1 = rf_value(id_f.rs1, rf_wr_en, wb_rd, wb_val, lastw_v, lastw_rd, lastw_val, rv1, ram_q1);
    rf2 = rf_value(id_f.rs2, rf_wr_en, wb_rd, wb_val, lastw_v, lastw_rd, lastw_val, rv2, ram_q2);

    // EX forwarding overrides MEM forwarding
    s1 = rf1;
    s2 = rf2;
    if (mem_v && mem_rd != '0) begin
      if (mem_rd == id_f.rs1) s1 = mem_res;
      if (mem_rd == id_f.rs2) s2 = mem_res;
    end
    if (ex_v && ex_f.rd != '0 && !ex_f.ld) begin
      if (ex_f.rd == id_f.rs1) s1 = ex_result;
      if (ex_f.rd == id_f.rs2) s2 = ex_result;
    end

    if (freeze_now || stall) begin
      fetch_address_next = fetch_address;
    end else if (redirect) begin
      fetch_address_next = ex_target;
    end else begin
      fetch_address_next = fetch_address + XLEN'(PC_STEP);
    end

    // read the operands of whatever sits in ID next cycle
    rd_addr1 = stall ? id_f.rs1 : new_rs1;
    rd_addr2 = stall ? id_f.rs2 : new_rs2;
  end

  phfc_ram #(
    .WIDTH(XLEN),
    .DEPTH(NUM_REGS)
  ) u_regfile (
    .clk       (clk),
    .wr_en     (rf_wr_en),
    .wr_addr   (wb_rd[AW-1:0]),
    .wr_data   (wb_val),
    .rd_en     (run),
    .rd_addr_a (rd_addr1[AW-1:0]),
    .rd_data_a (ram_q1),
    .rd_addr_b (rd_addr2[AW-1:0]),
    .rd_data_b (ram_q2)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      id_v             <= 1'b0;
      ex_v             <= 1'b0;
      mem_v            <= 1'b0;
      wb_v             <= 1'b0;
      fetch_address    <= RESET_PC[XLEN-1:0];
      freeze_remaining <= '0;
      written          <= '0;
      lastw_v          <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        freeze_remaining <= freeze_next;
      end
      if (run) begin
        wb_v          <= mem_v;
        mem_v         <= ex_v;
        ex_v          <= stall ? 1'b0 : id_eff_v;
        id_v          <= stall ? 1'b1 : !redirect;
        lastw_v       <= rf_wr_en;
        if (rf_wr_en) begin
          written[wb_rd[AW-1:0]] <= 1'b1;
        end
      end
      // a start_pc write takes precedence over the advance
      if (cfg_valid && cfg_ready) begin
        fetch_address <= cfg_data;
      end else if (run) begin
        fetch_address <= fetch_address_next;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (run) begin
      wb_rd     <= mem_rd;
      wb_val    <= mem_res;
      mem_rd    <= ex_f.rd;
      mem_ld    <= ex_f.ld;
      mem_val   <= ex_result;
      lastw_rd  <= wb_rd;
      lastw_val <= wb_val;
      rv1       <= written[rd_addr1[AW-1:0]];
      rv2       <= written[rd_addr2[AW-1:0]];
      if (stall) begin
        ex_f <= '0;
      end else begin
        ex_f.rd <= id_f.rd;
        ex_f.ld <= id_f.ld;
        if (!redirect) begin
          id_f.rs1 <= new_rs1;
          id_f.rs2 <= new_rs2;
          id_f.rd  <= new_rd;
          id_f.ld  <= new_is_load;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (step) begin
      if (freeze_now) begin
        issue_valid    <= 1'b0;
        issue_src1     <= '0;
        issue_src2     <= '0;
        load_use_stall <= 1'b0;
        frozen         <= 1'b1;
        commit_valid   <= 1'b0;
        commit_rd      <= '0;
        commit_value   <= '0;
      end else begin
        issue_valid    <= issue;
        issue_src1     <= issue ? s1 : '0;
        issue_src2     <= issue ? s2 : '0;
        load_use_stall <= stall;
        frozen         <= 1'b0;
        commit_valid   <= wb_v;
        commit_rd      <= wb_v ? wb_rd : '0;
        commit_value   <= (wb_v && wb_rd != '0) ? wb_val : '0;
      end
      next_fetch_pc <= fetch_address_next;
    end
  end

endmodule

// ===== verif/tb_pipeline_hazard_forward_control.sv =====
// Self-checking testbench for the pipeline hazard, forwarding and fetch control block.
`timescale 1ns / 1ps

module tb_pipeline_hazard_forward_control;
  import phfc_pkg::*;

  localparam int XLEN           = XLEN_DEF;
  localparam int PHASE_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    logic [REG_W-1:0] new_rs1;
    logic [REG_W-1:0] new_rs2;
    logic [REG_W-1:0] new_rd;
    logic             new_is_load;
    logic [XLEN-1:0]  ex_result;
    logic             ex_redirect;
    logic [XLEN-1:0]  ex_target;
    logic [XLEN-1:0]  mem_load_data;
    logic [LAT_W-1:0] mem_latency;
  } cycle_t;

  typedef struct {
    logic             issue_valid;
    logic [XLEN-1:0]  issue_src1;
    logic [XLEN-1:0]  issue_src2;
    logic             load_use_stall;
    logic             frozen;
    logic [XLEN-1:0]  next_fetch_pc;
    logic             commit_valid;
    logic [REG_W-1:0] commit_rd;
    logic [XLEN-1:0]  commit_value;
  } beat_t;

  // Cycle-accurate pipeline predictor plus the queue of result beats it owes
  class pipeline_scoreboard;
    logic [XLEN-1:0]  start_pc;
    logic [XLEN-1:0]  fetch_addr;
    logic [XLEN-1:0]  gpr [NUM_REGS_DEF];
    bit               id_v;
    id_fields_t       id_q;
    bit               ex_v;
    ex_fields_t       ex_q;
    bit               mem_v;
    bit               mem_ld;
    logic [REG_W-1:0] mem_rd;
    logic [XLEN-1:0]  mem_val;
    bit               wb_v;
    logic [REG_W-1:0] wb_rd;
    logic [XLEN-1:0]  wb_val;
    logic [LAT_W-1:0] freeze_left;
    bit               fetch_dropped;
    beat_t            expected_beats [$];
    int n_errors, n_beats, n_issued, n_stalls, n_frozen, n_redirects, n_commits;

    function new();
      start_pc = RESET_PC;
      fetch_addr = RESET_PC;
      foreach (gpr[i]) gpr[i] = '0;
      id_v = 0;
      ex_v = 0;
      mem_v = 0;
      wb_v = 0;
      id_q = '0;
      ex_q = '0;
      mem_ld = 0;
      mem_rd = '0;
      mem_val = '0;
      wb_rd = '0;
      wb_val = '0;
      freeze_left = '0;
      fetch_dropped = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void write_start_pc(logic [XLEN-1:0] value);
      start_pc = value;
      fetch_addr = value;
    endfunction

    function logic [XLEN-1:0] read_gpr(logic [REG_W-1:0] r);
      if (r == 0 || r >= NUM_REGS_DEF) return '0;
      return gpr[r];
    endfunction

    function void note_cycle(cycle_t c);
      beat_t           b;
      bit              redirect;
      bit              stall;
      logic [XLEN-1:0] mem_res;
      logic [XLEN-1:0] s1;
      logic [XLEN-1:0] s2;
      b = '{default: '0};
      stall = 0;
      n_beats++;
      if (freeze_left != 0) begin
        freeze_left--;
        b.frozen = 1'b1;
        b.next_fetch_pc = fetch_addr;
        fetch_dropped = 1;
        n_frozen++;
        expected_beats.push_back(b);
        return;
      end
      // retire first so that ID reads see the write
      if (wb_v) begin
        b.commit_valid = 1'b1;
        b.commit_rd = wb_rd;
        n_commits++;
        if (wb_rd != 0) begin
          b.commit_value = wb_val;
          if (wb_rd < NUM_REGS_DEF) gpr[wb_rd] = wb_val;
        end
      end
      mem_res = mem_val;
      if (mem_v && mem_ld) begin
        mem_res = c.mem_load_data;
        if (c.mem_latency > 1) freeze_left = c.mem_latency - LAT_W'(1);
      end
      redirect = ex_v && c.ex_redirect;
      if (redirect) begin
        id_v = 0;
        n_redirects++;
      end
      if (id_v) begin
        if (ex_v && ex_q.ld && ex_q.rd != 0 && (ex_q.rd == id_q.rs1 || ex_q.rd == id_q.rs2)) begin
          stall = 1;
          n_stalls++;
        end else begin
          s1 = read_gpr(id_q.rs1);
          s2 = read_gpr(id_q.rs2);
          if (mem_v && mem_rd != 0) begin
            if (mem_rd == id_q.rs1) s1 = mem_res;
            if (mem_rd == id_q.rs2) s2 = mem_res;
          end
          // EX wins over MEM
          if (ex_v && ex_q.rd != 0 && !ex_q.ld) begin
            if (ex_q.rd == id_q.rs1) s1 = c.ex_result;
            if (ex_q.rd == id_q.rs2) s2 = c.ex_result;
          end
          b.issue_valid = 1'b1;
          b.issue_src1 = s1;
          b.issue_src2 = s2;
          n_issued++;
        end
      end
      wb_v = mem_v;
      wb_rd = mem_rd;
      wb_val = mem_res;
      mem_v = ex_v;
      mem_rd = ex_q.rd;
      mem_ld = ex_q.ld;
      mem_val = c.ex_result;
      if (stall) begin
        ex_v = 0;
        ex_q = '0;
      end else begin
        ex_v = id_v;
        ex_q.rd = id_q.rd;
        ex_q.ld = id_q.ld;
        if (redirect) begin
          id_v = 0;
          fetch_addr = c.ex_target;
        end else begin
          id_v = 1;
          id_q.rs1 = c.new_rs1;
          id_q.rs2 = c.new_rs2;
          id_q.rd = c.new_rd;
          id_q.ld = c.new_is_load;
          fetch_addr = fetch_addr + XLEN'(PC_STEP);
        end
      end
      b.load_use_stall = stall;
      b.next_fetch_pc = fetch_addr;
      fetch_dropped = stall;
      expected_beats.push_back(b);
    endfunction

    function void compare(string field, logic [XLEN-1:0] want, logic [XLEN-1:0] seen);
      if (seen !== want) begin
        $error("%s: expected %0h, got %0h", field, want, seen);
        n_errors++;
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with no expectation waiting");
        n_errors++;
        return;
      end
      want = expected_beats.pop_front();
      compare("issue_valid", want.issue_valid, got.issue_valid);
      compare("issue_src1", want.issue_src1, got.issue_src1);
      compare("issue_src2", want.issue_src2, got.issue_src2);
      compare("load_use_stall", want.load_use_stall, got.load_use_stall);
      compare("frozen", want.frozen, got.frozen);
      compare("next_fetch_pc", want.next_fetch_pc, got.next_fetch_pc);
      compare("commit_valid", want.commit_valid, got.commit_valid);
      compare("commit_rd", want.commit_rd, got.commit_rd);
      compare("commit_value", want.commit_value, got.commit_value);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [XLEN-1:0]  cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [REG_W-1:0] new_rs1 = '0;
  logic [REG_W-1:0] new_rs2 = '0;
  logic [REG_W-1:0] new_rd = '0;
  logic             new_is_load = 1'b0;
  logic [XLEN-1:0]  ex_result = '0;
  logic             ex_redirect = 1'b0;
  logic [XLEN-1:0]  ex_target = '0;
  logic [XLEN-1:0]  mem_load_data = '0;
  logic [LAT_W-1:0] mem_latency = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             issue_valid;
  logic [XLEN-1:0]  issue_src1;
  logic [XLEN-1:0]  issue_src2;
  logic             load_use_stall;
  logic             frozen;
  logic [XLEN-1:0]  next_fetch_pc;
  logic             commit_valid;
  logic [REG_W-1:0] commit_rd;
  logic [XLEN-1:0]  commit_value;

  pipeline_scoreboard sb = new();
  cycle_t held;
  bit     quiet = 0;
  int     in_gap_pct = 10;
  int     out_gap_pct = 10;
  int     n_pc_writes = 0;

  pipeline_hazard_forward_control dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .new_rs1(new_rs1), .new_rs2(new_rs2), .new_rd(new_rd), .new_is_load(new_is_load),
    .ex_result(ex_result), .ex_redirect(ex_redirect), .ex_target(ex_target),
    .mem_load_data(mem_load_data), .mem_latency(mem_latency),
    .out_valid(out_valid), .out_ready(out_ready),
    .issue_valid(issue_valid), .issue_src1(issue_src1), .issue_src2(issue_src2),
    .load_use_stall(load_use_stall), .frozen(frozen), .next_fetch_pc(next_fetch_pc),
    .commit_valid(commit_valid), .commit_rd(commit_rd), .commit_value(commit_value)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_reg();
    if ($urandom_range(0, 9) < 7) return REG_W'($urandom_range(0, 7));
    return REG_W'($urandom_range(0, 31));
  endfunction

  function automatic cycle_t mk(input logic [REG_W-1:0] rs1, rs2, rd, input logic ld,
                                input logic [XLEN-1:0] exr, input logic redir,
                                input logic [XLEN-1:0] tgt, input logic [XLEN-1:0] ldd,
                                input logic [LAT_W-1:0] lat);
    cycle_t c;
    c.new_rs1 = rs1;
    c.new_rs2 = rs2;
    c.new_rd = rd;
    c.new_is_load = ld;
    c.ex_result = exr;
    c.ex_redirect = redir;
    c.ex_target = tgt;
    c.mem_load_data = ldd;
    c.mem_latency = lat;
    return c;
  endfunction

  // Mostly a well-formed instruction stream; refetch after a stall, rare noise
  function automatic cycle_t rand_cycle();
    cycle_t c;
    int unsigned r;
    c = held;
    if (sb.freeze_left != 0 || !sb.fetch_dropped || $urandom_range(0, 19) == 0) begin
      c.new_rs1 = pick_reg();
      c.new_rs2 = pick_reg();
      c.new_rd = pick_reg();
      c.new_is_load = $urandom_range(0, 99) < 30;
    end
    c.ex_result = {$urandom, $urandom};
    c.ex_redirect = $urandom_range(0, 99) < (sb.ex_v ? 10 : 4);
    case ($urandom_range(0, 3))
      0: c.ex_target = {$urandom, $urandom};
      1: c.ex_target = '1 - $urandom_range(0, 15);
      2: c.ex_target = sb.fetch_addr + $urandom_range(0, 64);
      default: c.ex_target = {32'h0, $urandom};
    endcase
    c.mem_load_data = {$urandom, $urandom};
    r = $urandom_range(0, 99);
    if (sb.mem_v && sb.mem_ld && sb.freeze_left == 0) begin
      if (r < 85) c.mem_latency = LAT_W'($urandom_range(0, 1));
      else if (r < 98) c.mem_latency = LAT_W'($urandom_range(2, 6));
      else c.mem_latency = LAT_W'($urandom_range(0, 255));
    end else begin
      c.mem_latency = LAT_W'($urandom_range(0, 255));
    end
    return c;
  endfunction

  task automatic send_beat(input cycle_t c);
    in_valid <= 1'b1;
    new_rs1 <= c.new_rs1;
    new_rs2 <= c.new_rs2;
    new_rd <= c.new_rd;
    new_is_load <= c.new_is_load;
    ex_result <= c.ex_result;
    ex_redirect <= c.ex_redirect;
    ex_target <= c.ex_target;
    mem_load_data <= c.mem_load_data;
    mem_latency <= c.mem_latency;
    do @(posedge clk); while (!in_ready);
    sb.note_cycle(c);
    held = c;
  endtask

  task automatic pause_in();
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Feed noise while the pipeline is frozen
  task automatic ride_freeze();
    while (sb.freeze_left != 0) begin
      send_beat(rand_cycle());
      pause_in();
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [XLEN-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_start_pc(value);
    n_pc_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Load followed by fillers; give the load the requested latency once it sits in MEM
  task automatic slow_load(input logic [LAT_W-1:0] lat);
    cycle_t c;
    ride_freeze();
    for (int k = 0; k < 4; k++) begin
      c = mk(0, 0, (k == 0) ? 5'd4 : 5'd0, k == 0, {$urandom, $urandom}, 1'b0, '0,
             {$urandom, $urandom}, 8'd0);
      if (sb.mem_v && sb.mem_ld) c.mem_latency = lat;
      send_beat(c);
    end
    ride_freeze();
  endtask

  task automatic run_directed();
    cycle_t d [$];
    // redirect with EX empty, latency while MEM empty, EX forward, load-use, refetch
    d.push_back(mk(0, 0, 1, 0, '0, 1, '1, '0, 8'hFF));
    d.push_back(mk(1, 0, 2, 1, '1, 0, '0, '1, 8'hFF));
    d.push_back(mk(2, 1, 3, 0, '1, 0, '0, '0, 0));
    d.push_back(mk(3, 31, 31, 0, '0, 0, '0, '0, 0));
    d.push_back(mk(3, 31, 31, 0, '0, 0, '0, '1, 1));
    // write to register zero then read it
    d.push_back(mk(0, 0, 0, 0, 64'h0123_4567_89AB_CDEF, 0, '0, '0, 0));
    d.push_back(mk(0, 0, 5, 0, '1, 0, '0, '0, 0));
    d.push_back(mk(0, 5, 5, 0, 64'h5555_5555_5555_5555, 0, '0, '0, 0));
    d.push_back(mk(5, 5, 6, 0, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, '0, 0));
    d.push_back(mk(0, 0, 7, 1, '0, 0, '0, '0, 0));
    d.push_back(mk(7, 7, 8, 0, '0, 0, '0, '0, 0));
    d.push_back(mk(7, 7, 8, 0, '0, 0, '0, 64'hFEDC_BA98_7654_3210, 0));
    d.push_back(mk(8, 0, 9, 0, '1, 0, '0, '0, 2));
    // taken redirect to the top of the address space so pc+4 wraps
    d.push_back(mk(8, 9, 10, 0, '1, 1, 64'hFFFF_FFFF_FFFF_FFFC, '0, 0));
    d.push_back(mk(31, 31, 31, 1, '0, 0, '0, '0, 0));
    d.push_back(mk(31, 30, 1, 0, '0, 0, '0, '0, 0));
    d.push_back(mk(31, 30, 1, 0, '0, 0, '0, '1, 0));
    d.push_back(mk(1, 31, 0, 0, '1, 0, '0, '0, 0));
    foreach (d[i]) begin
      ride_freeze();
      send_beat(d[i]);
      pause_in();
    end
    slow_load(8'd2);
    slow_load(8'd255);
  endtask

  initial begin
    logic [XLEN-1:0] pc_settings [6];
    int n;
    pc_settings[0] = RESET_PC;
    pc_settings[1] = '1;
    pc_settings[2] = '0;
    pc_settings[3] = 64'hFFFF_FFFF_FFFF_FFF8;
    pc_settings[4] = {$urandom, $urandom};
    pc_settings[5] = RESET_PC;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_start_pc(pc_settings[p]);
      if (p == 5) quiet = 1;
      n = 0;
      while (n < PHASE_CYCLES) begin
        if (n % 20 == 0) in_gap_pct = pick_gap_pct();
        n++;
        send_beat(rand_cycle());
        pause_in();
      end
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d cycles over %0d start_pc writes: %0d issued, %0d load-use stalls",
             sb.n_beats, n_pc_writes, sb.n_issued, sb.n_stalls);
    $display("%0d frozen cycles, %0d redirects taken, %0d commits",
             sb.n_frozen, sb.n_redirects, sb.n_commits);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side back-pressure in bursts; none in the final phase
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) out_gap_pct = pick_gap_pct();
      if (!quiet && $urandom_range(0, 99) < out_gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t got;
    if (!rst && out_valid && out_ready) begin
      got.issue_valid = issue_valid;
      got.issue_src1 = issue_src1;
      got.issue_src2 = issue_src2;
      got.load_use_stall = load_use_stall;
      got.frozen = frozen;
      got.next_fetch_pc = next_fetch_pc;
      got.commit_valid = commit_valid;
      got.commit_rd = commit_rd;
      got.commit_value = commit_value;
      sb.check_beat(got);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (rst) @(posedge clk);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/phfc_pkg.sv
rtl/core/phfc_ram.sv
rtl/core/pipeline_hazard_forward_control.sv
verif/tb_pipeline_hazard_forward_control.sv
